>>> hdl/rwc_pkg.sv
`default_nettype none
package rwc_pkg;

    localparam int unsigned TAPS      = 9;
    localparam int unsigned COEF_W    = 16;
    localparam int unsigned SUM_W     = 30;
    localparam int unsigned WSUM_W    = 20;
    localparam int unsigned CHANNELS  = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned MAX_H     = 4096;
    localparam int unsigned H_W       = 13;
    localparam int unsigned ROW_W     = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_COEF_A = 3'd2,
        REG_COEF_B = 3'd3,
        REG_COEF_C = 3'd4,
        REG_NORM   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CHANNELS-1:0][SUM_W-1:0] sums;
        logic [WSUM_W-1:0]              wsum;
    } t_acc;

endpackage
`default_nettype wire

>>> hdl/rwc_if.sv
`default_nettype none
interface rwc_pix_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_in;
    logic        is_padding;
    modport source (output valid, pixel_in, is_padding, input ready);
    modport sink (input valid, pixel_in, is_padding, output ready);
endinterface

interface rwc_pix_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic        zero_weight;
    logic        last_of_frame;
    modport source (output valid, pixel_out, zero_weight, last_of_frame, input ready);
    modport sink (input valid, pixel_out, zero_weight, last_of_frame, output ready);
endinterface

interface rwc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rwc_pkg::CFG_IDX_W-1:0]  index;
    logic [63:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/rwc_cell.sv
`default_nettype none
module rwc_cell (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire [31:0]                   i_pixel,
    input  wire [rwc_pkg::COEF_W-1:0]    i_coef,
    input  rwc_pkg::t_acc                i_acc,
    output rwc_pkg::t_acc                o_acc
);
    rwc_pkg::t_acc r_acc;
    rwc_pkg::t_acc n_acc;

    always_comb begin
        logic signed [24:0] prod;
        n_acc = i_acc;
        for (int c = 0; c < rwc_pkg::CHANNELS; c++) begin
            prod = $signed({1'b0, i_pixel[8*c +: 8]}) * $signed(i_coef);
            if (i_en) begin
                n_acc.sums[c] = i_acc.sums[c]
                    + rwc_pkg::SUM_W'($signed(prod));
            end
        end
        if (i_en) begin
            n_acc.wsum = i_acc.wsum + rwc_pkg::WSUM_W'($signed(i_coef));
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

>>> hdl/rwc_div.sv
`default_nettype none
module rwc_div (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  rwc_pkg::t_acc  i_acc,
    output logic           o_done,
    output logic [31:0]    o_pix
);
    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                                           r_state;
    logic [2:0]                                       r_bit;
    logic [rwc_pkg::CHANNELS-1:0][rwc_pkg::SUM_W-1:0] r_rem;
    logic [rwc_pkg::SUM_W-1:0]                        r_den;
    logic [rwc_pkg::CHANNELS-1:0][7:0]                r_q;
    logic [rwc_pkg::CHANNELS-1:0]                     r_nil;
    logic [rwc_pkg::CHANNELS-1:0]                     r_sat;
    logic                                             r_done;

    always_ff @(posedge i_clk) begin
        logic [rwc_pkg::SUM_W-1:0] mag;
        logic [rwc_pkg::SUM_W-1:0] den;
        logic [rwc_pkg::SUM_W-1:0] sub;
        logic                      wneg;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_bit   <= '0;
        end else begin
            r_done <= (r_state == ST_RUN) && (r_bit == 3'd0);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        wneg = i_acc.wsum[rwc_pkg::WSUM_W-1];
                        den  = rwc_pkg::SUM_W'(wneg ? -$signed(i_acc.wsum)
                                                    : $signed(i_acc.wsum));
                        den  = den & {{(rwc_pkg::SUM_W-rwc_pkg::WSUM_W){1'b0}},
                                      {rwc_pkg::WSUM_W{1'b1}}};
                        r_den <= den;
                        for (int c = 0; c < rwc_pkg::CHANNELS; c++) begin
                            mag = i_acc.sums[c][rwc_pkg::SUM_W-1] ? -i_acc.sums[c]
                                                                 : i_acc.sums[c];
                            r_rem[c] <= mag;
                            r_q[c]   <= '0;
                            r_nil[c] <= (i_acc.sums[c] == '0)
                                || (i_acc.sums[c][rwc_pkg::SUM_W-1] != wneg);
                            r_sat[c] <= mag >= (den << 8);
                        end
                        r_bit   <= 3'd7;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    for (int c = 0; c < rwc_pkg::CHANNELS; c++) begin
                        sub = r_den << r_bit;
                        if (r_rem[c] >= sub) begin
                            r_rem[c]      <= r_rem[c] - sub;
                            r_q[c][r_bit] <= 1'b1;
                        end
                    end
                    if (r_bit == 3'd0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < rwc_pkg::CHANNELS; c++) begin
            o_pix[8*c +: 8] = r_nil[c] ? 8'd0 : (r_sat[c] ? 8'hFF : r_q[c]);
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

>>> hdl/rgba_window_convolution.sv
// Channel  | Dir | Payload                                  | Handshake
// i_pix    | in  | pixel_in[31:0], is_padding               | valid/ready
// o_pix    | out | pixel_out[31:0], zero_weight, last_of_frame | valid/ready
// i_cfg    | in  | index[2:0], data[63:0]                   | valid/ready, always ready
// One item at a time: it is placed, then read through the row of nine tap
// cells fed by the single line-store read port, then through the divider when
// normalising with a nonzero weight sum, and then loaded into the output
// register; an item that produces no result goes back to idle once placed.
// Reset is synchronous, active low; the line store is not cleared.
// A result waits in the output register while the next item is taken; the
// block stalls only when a new result meets an output not yet taken.
`default_nettype none
module rgba_window_convolution #(
    parameter int unsigned MAX_WIDTH      = 1024,
    parameter int unsigned COEF_FRAC_BITS = 12
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    rwc_pix_in_if.sink         i_pix,
    rwc_pix_out_if.source      o_pix,
    rwc_cfg_if.sink            i_cfg
);
    localparam int unsigned W_W    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned IDX_W  = rwc_pkg::ROW_W + W_W;
    localparam int unsigned ADDR_W = $clog2(2 * MAX_WIDTH + 3);

    typedef enum logic [2:0] {
        S_IDLE, S_POS, S_DECIDE, S_READ, S_DRAIN, S_POST, S_DIV, S_OUT
    } t_state;

    logic [10:0]                 r_cfg_width;
    logic [12:0]                 r_cfg_height;
    logic [63:0]                 r_coef_a;
    logic [63:0]                 r_coef_b;
    logic [15:0]                 r_coef_c;
    logic                        r_norm;

    t_state                      r_state;
    logic [31:0]                 r_pixel;
    logic                        r_pad;
    logic [W_W-1:0]              r_in_col;
    logic [rwc_pkg::ROW_W-1:0]   r_in_row;
    logic [W_W-1:0]              r_out_col;
    logic [rwc_pkg::ROW_W-1:0]   r_out_row;
    logic [IDX_W-1:0]            r_nin;
    logic [IDX_W-1:0]            r_nout;
    logic [IDX_W-1:0]            r_frame;
    logic [1:0]                  r_ci;
    logic [1:0]                  r_cj;
    logic [3:0]                  r_step;
    logic [31:0]                 r_rd_data;
    logic                        r_rd_valid;
    logic                        r_rd_inb;
    logic [3:0]                  r_rd_step;
    logic                        r_last;
    logic                        r_zero;
    logic [31:0]                 r_res;
    logic                        r_out_valid;
    logic [31:0]                 r_out_pix;
    logic                        r_out_zero;
    logic                        r_out_last;

    logic [31:0]                 mem [2**ADDR_W];

    logic [W_W-1:0]              w_eff;
    logic [rwc_pkg::H_W-1:0]     h_eff;
    logic [rwc_pkg::COEF_W-1:0]  w_coef [rwc_pkg::TAPS];
    rwc_pkg::t_acc               w_acc [rwc_pkg::TAPS+1];
    logic [ADDR_W-1:0]           w_rd_addr;
    logic                        w_rd_inb;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [31:0]                 w_div_pix;
    logic [31:0]                 w_plain;
    logic                        w_in_acc;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = W_W'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = rwc_pkg::H_W'(1);
        end else if (32'(r_cfg_height) > 32'(rwc_pkg::MAX_H)) begin
            h_eff = rwc_pkg::H_W'(rwc_pkg::MAX_H);
        end else begin
            h_eff = r_cfg_height;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_coef[k]     = r_coef_a[16*k +: 16];
            w_coef[k + 4] = r_coef_b[16*k +: 16];
        end
        w_coef[8] = r_coef_c;
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 11'd1024;
            r_cfg_height <= 13'd1024;
            r_coef_a     <= '0;
            r_coef_b     <= 64'd4096;
            r_coef_c     <= '0;
            r_norm       <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rwc_pkg::REG_WIDTH:  r_cfg_width  <= i_cfg.data[10:0];
                rwc_pkg::REG_HEIGHT: r_cfg_height <= i_cfg.data[12:0];
                rwc_pkg::REG_COEF_A: r_coef_a     <= i_cfg.data;
                rwc_pkg::REG_COEF_B: r_coef_b     <= i_cfg.data;
                rwc_pkg::REG_COEF_C: r_coef_c     <= i_cfg.data[15:0];
                rwc_pkg::REG_NORM:   r_norm       <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [ADDR_W-1:0]            base;
        logic [W_W:0]                 nx;
        logic [rwc_pkg::ROW_W:0]      ny;
        base = r_nout[ADDR_W-1:0] + ADDR_W'(r_ci) - ADDR_W'(1);
        unique case (r_cj)
            2'd0:    w_rd_addr = base - ADDR_W'(w_eff);
            2'd2:    w_rd_addr = base + ADDR_W'(w_eff);
            default: w_rd_addr = base;
        endcase
        nx = (W_W+1)'(r_out_col) + (W_W+1)'(r_ci);
        ny = (rwc_pkg::ROW_W+1)'(r_out_row) + (rwc_pkg::ROW_W+1)'(r_cj);
        w_rd_inb = (nx != '0) && (nx <= (W_W+1)'(w_eff))
                && (ny != '0) && (ny <= (rwc_pkg::ROW_W+1)'(h_eff));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE && r_nin < r_frame && !r_pad) begin
            mem[r_nin[ADDR_W-1:0]] <= r_pixel;
        end
        if (r_state == S_READ) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    assign w_acc[0] = '0;

    for (genvar k = 0; k < rwc_pkg::TAPS; k++) begin : g_cell
        rwc_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (r_rd_valid && r_rd_inb && r_rd_step == 4'(k)),
            .i_pixel (r_rd_data),
            .i_coef  (w_coef[k]),
            .i_acc   (w_acc[k]),
            .o_acc   (w_acc[k+1])
        );
    end

    assign w_div_start = (r_state == S_POST) && r_norm
                      && (w_acc[rwc_pkg::TAPS].wsum != '0);

    rwc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_acc   (w_acc[rwc_pkg::TAPS]),
        .o_done  (w_div_done),
        .o_pix   (w_div_pix)
    );

    always_comb begin
        logic signed [rwc_pkg::SUM_W-1:0] s;
        logic signed [rwc_pkg::SUM_W-1:0] q;
        for (int c = 0; c < rwc_pkg::CHANNELS; c++) begin
            s = $signed(w_acc[rwc_pkg::TAPS].sums[c]);
            q = s >>> COEF_FRAC_BITS;
            if (s <= 0) begin
                w_plain[8*c +: 8] = 8'd0;
            end else if (q > 255) begin
                w_plain[8*c +: 8] = 8'hFF;
            end else begin
                w_plain[8*c +: 8] = q[7:0];
            end
        end
    end

    assign i_pix.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_pix.valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        logic [IDX_W:0] nin1;
        logic [W_W:0]   col1;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= (r_state == S_READ);
            if (r_state == S_OUT && (!r_out_valid || o_pix.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_pixel <= i_pix.pixel_in;
                        r_pad   <= i_pix.is_padding;
                        if (r_in_col >= w_eff) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + 1'b1;
                        end
                        if (r_out_col >= w_eff) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + 1'b1;
                        end
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_nin   <= IDX_W'(r_in_row) * IDX_W'(w_eff) + IDX_W'(r_in_col);
                    r_nout  <= IDX_W'(r_out_row) * IDX_W'(w_eff) + IDX_W'(r_out_col);
                    r_frame <= IDX_W'(w_eff) * IDX_W'(h_eff);
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_nin < r_frame && r_pad) begin
                        r_state <= S_IDLE;
                    end else begin
                        col1 = (W_W+1)'(r_in_col) + 1'b1;
                        if (col1 >= (W_W+1)'(w_eff)) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + 1'b1;
                        end else begin
                            r_in_col <= col1[W_W-1:0];
                        end
                        nin1 = (IDX_W+1)'(r_nin) + 1'b1;
                        if (nin1 < (IDX_W+1)'(r_nout)
                            || nin1 - (IDX_W+1)'(r_nout) < (IDX_W+1)'(w_eff) + 1'b1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ci    <= '0;
                            r_cj    <= '0;
                            r_step  <= '0;
                            r_last  <= nin1 - nin1 + (IDX_W+1)'(r_nout) + 1'b1
                                       >= (IDX_W+1)'(r_frame);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_rd_inb   <= w_rd_inb;
                    r_rd_step  <= r_step;
                    r_step     <= r_step + 1'b1;
                    if (r_cj == 2'd2) begin
                        r_cj <= '0;
                        r_ci <= r_ci + 1'b1;
                    end else begin
                        r_cj <= r_cj + 1'b1;
                    end
                    if (r_step == 4'(rwc_pkg::TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_POST;
                end
                S_POST: begin
                    r_zero <= r_norm && (w_acc[rwc_pkg::TAPS].wsum == '0);
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_res   <= r_norm ? 32'd0 : w_plain;
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res   <= w_div_pix;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_pix.ready) begin
                        r_out_pix   <= r_res;
                        r_out_zero  <= r_zero;
                        r_out_last  <= r_last;
                        if (r_last) begin
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                        end else begin
                            col1 = (W_W+1)'(r_out_col) + 1'b1;
                            if (col1 >= (W_W+1)'(w_eff)) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + 1'b1;
                            end else begin
                                r_out_col <= col1[W_W-1:0];
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.pixel_out     = r_out_pix;
    assign o_pix.zero_weight   = r_out_zero;
    assign o_pix.last_of_frame = r_out_last;
endmodule
`default_nettype wire
